// File: rtl/core/nfpa_pkg.sv
package nfpa_pkg;
   localparam int PagesDef     = 1024;
   localparam int EntriesDef   = 64;
   localparam int PageBytesDef = 4096;

   localparam logic [2:0] StOk      = 3'd0;
   localparam logic [2:0] StNoSpace = 3'd1;
   localparam logic [2:0] StZero    = 3'd2;
   localparam logic [2:0] StFull    = 3'd3;
   localparam logic [2:0] StUnknown = 3'd4;

   localparam logic FuncAlloc = 1'b0;
   localparam logic FuncFree  = 1'b1;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SLOT,
      S_SCAN_RD,
      S_SCAN,
      S_MARK,
      S_FREE_RD,
      S_FREE,
      S_REL,
      S_DONE
   } state_type;
endpackage

// File: rtl/core/next_fit_page_allocator.sv
// Allocate: after the transfer in, S_SLOT picks the free slot, S_SCAN_RD reads the
// bitmap, S_SCAN looks at up to PAGES pages and S_MARK marks each page of the run,
// then S_DONE gives the result. Zero size or too few free pages: straight to S_DONE.
// Free: S_FREE_RD and S_FREE per slot looked up (up to ENTRIES), S_REL per page, then
// S_DONE. One request at a time; the page bitmap memory port (one page per cycle)
// paces scan, mark and release. Reset (synchronous, active high) starts a clearing pass over all PAGES pages.
module next_fit_page_allocator #(
   parameter int PAGES      = nfpa_pkg::PagesDef,
   parameter int ENTRIES    = nfpa_pkg::EntriesDef,
   parameter int PAGE_BYTES = nfpa_pkg::PageBytesDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [31:0] req_size_bytes,
   input  logic [31:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_start_address,
   output logic [2:0]  rsp_status,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import nfpa_pkg::*;

   localparam int PW = $clog2(PAGES);
   localparam int CW = PW + 1;
   localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int EW = $clog2(ENTRIES + 1);
   localparam int BW = $clog2(PAGE_BYTES);
   localparam int NW = 33 - BW;

   state_type state_ff, state_in;

   logic [31:0]   base_ff;
   logic [PW-1:0] start_ff, start_in;
   logic [CW-1:0] free_ff, free_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;

   logic [NW-1:0] need_ff, need_in;
   logic [31:0]   addr_ff;
   logic [SW-1:0] slot_ff, slot_in;
   logic [EW-1:0] sidx_ff, sidx_in;
   logic [CW-1:0] k_ff, k_in;
   logic [PW-1:0] p_ff, p_in;
   logic [NW-1:0] run_ff, run_in;
   logic [PW-1:0] first_ff, first_in;
   logic [PW-1:0] last_ff, last_in;
   logic [PW-1:0] cur_ff, cur_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_addr_ff, rsp_addr_in;
   logic [2:0]    rsp_st_ff, rsp_st_in;

   logic          pg_we;
   logic [PW-1:0] pg_wa, pg_ra;
   logic          pg_wd, pg_rd;
   logic          sl_we;
   logic [SW-1:0] sl_ra;
   logic [2*PW-1:0] sl_rd;

   logic          accept;
   logic [32:0]   size_ext;
   logic [31:0]   slot_addr;

   nfpa_ram #(.WIDTH(1), .DEPTH(PAGES)) u_pages (
      .clock(clock), .wr_en(pg_we), .wr_addr(pg_wa), .wr_data(pg_wd),
      .rd_addr(pg_ra), .rd_data(pg_rd)
   );

   nfpa_ram #(.WIDTH(2*PW), .DEPTH(ENTRIES)) u_slots (
      .clock(clock), .wr_en(sl_we), .wr_addr(slot_ff), .wr_data({first_ff, last_ff}),
      .rd_addr(sl_ra), .rd_data(sl_rd)
   );

   // config port
   assign csr_pready = 1'b1;
   assign csr_prdata = base_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0) begin
         base_ff <= csr_pwdata;
      end
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_start_address = rsp_addr_ff;
   assign rsp_status = rsp_st_ff;
   assign size_ext  = {1'b0, req_size_bytes} + 33'(PAGE_BYTES - 1);
   assign slot_addr = base_ff + (32'(sl_rd[2*PW-1:PW]) << BW);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:   if (cur_ff == PW'(PAGES - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (accept) begin
               if (req_func == FuncFree) state_in = S_FREE_RD;
               else if (req_size_bytes == '0 || NW'(size_ext >> BW) > NW'(free_ff))
                  state_in = S_DONE;
               else state_in = S_SLOT;
            end
         end
         S_SLOT:    state_in = (&valid_ff) ? S_DONE : S_SCAN_RD;
         S_SCAN_RD: state_in = S_SCAN;
         S_SCAN: begin
            if (!pg_rd && run_in == need_ff) state_in = S_MARK;
            else if (k_ff == CW'(PAGES - 1)) state_in = S_DONE;
         end
         S_MARK:    if (cur_ff == last_ff) state_in = S_DONE;
         S_FREE_RD: state_in = S_FREE;
         S_FREE: begin
            if (valid_ff[sidx_ff[SW-1:0]] && slot_addr == addr_ff) state_in = S_REL;
            else if (sidx_ff == EW'(ENTRIES - 1)) state_in = S_DONE;
            else state_in = S_FREE_RD;
         end
         S_REL:     if (cur_ff == last_ff) state_in = S_DONE;
         S_DONE:    state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      start_in = start_ff;  free_in = free_ff;  valid_in = valid_ff;
      need_in = need_ff;  slot_in = slot_ff;  sidx_in = sidx_ff;
      k_in = k_ff;  p_in = p_ff;  run_in = run_ff;
      first_in = first_ff;  last_in = last_ff;  cur_in = cur_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_addr_in = rsp_addr_ff;  rsp_st_in = rsp_st_ff;
      pg_we = 1'b0;  pg_wa = cur_ff;  pg_wd = 1'b0;  pg_ra = p_ff;
      sl_we = 1'b0;  sl_ra = sidx_ff[SW-1:0];
      unique case (state_ff)
         S_CLEAR: begin
            pg_we = 1'b1;
            cur_in = cur_ff + 1'b1;
         end
         S_IDLE: begin
            need_in = NW'(size_ext >> BW);
            sidx_in = '0;  slot_in = '0;
            // a waiting result keeps its payload until its transfer
            if (accept) begin
               rsp_addr_in = '0;  rsp_st_in = StOk;
               if (req_func == FuncAlloc) begin
                  if (req_size_bytes == '0) rsp_st_in = StZero;
                  else rsp_st_in = StNoSpace;
               end
            end
            sl_ra = '0;
         end
         S_SLOT: begin
            for (int i = ENTRIES - 1; i >= 0; i--)
               if (!valid_ff[i]) slot_in = SW'(i);
            rsp_st_in = StFull;
            k_in = '0;  p_in = start_ff;  run_in = '0;
            pg_ra = start_ff;
         end
         S_SCAN_RD: begin
            pg_ra = p_ff;
            rsp_st_in = StNoSpace;
         end
         S_SCAN: begin
            run_in = run_ff;
            if (p_ff == '0 && k_ff != '0) run_in = '0;
            if (!pg_rd) begin
               if (run_in == '0) first_in = p_ff;
               run_in = run_in + 1'b1;
               if (run_in == need_ff) begin
                  last_in = p_ff;
                  cur_in = (run_in == NW'(1)) ? p_ff : first_in;
               end
            end else begin
               run_in = '0;
            end
            k_in = k_ff + 1'b1;
            p_in = (p_ff == PW'(PAGES - 1)) ? '0 : p_ff + 1'b1;
            pg_ra = p_in;
         end
         S_MARK: begin
            pg_we = 1'b1;  pg_wd = 1'b1;
            cur_in = cur_ff + 1'b1;
            if (cur_ff == last_ff) begin
               sl_we = 1'b1;
               valid_in[slot_ff] = 1'b1;
               free_in = free_ff - CW'(need_ff);
               start_in = (last_ff == PW'(PAGES - 1)) ? '0 : last_ff + 1'b1;
               rsp_addr_in = base_ff + (32'(first_ff) << BW);
               rsp_st_in = StOk;
            end
         end
         S_FREE_RD: begin
            sl_ra = sidx_ff[SW-1:0];
            rsp_st_in = StUnknown;
         end
         S_FREE: begin
            first_in = sl_rd[2*PW-1:PW];
            last_in = sl_rd[PW-1:0];
            cur_in = sl_rd[2*PW-1:PW];
            slot_in = sidx_ff[SW-1:0];
            sidx_in = sidx_ff + 1'b1;
         end
         S_REL: begin
            pg_we = 1'b1;  pg_wd = 1'b0;
            free_in = free_ff + CW'(1);
            cur_in = cur_ff + 1'b1;
            if (cur_ff == last_ff) begin
               valid_in[slot_ff] = 1'b0;
               rsp_st_in = StOk;
            end
         end
         S_DONE: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         start_ff <= '0;
         free_ff <= CW'(PAGES);
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cur_ff <= '0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         free_ff <= free_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= req_address;
      end
      need_ff <= need_in;
      slot_ff <= slot_in;
      sidx_ff <= sidx_in;
      k_ff <= k_in;
      p_ff <= p_in;
      run_ff <= run_in;
      first_ff <= first_in;
      last_ff <= last_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_st_ff <= rsp_st_in;
   end
endmodule

// File: rtl/core/nfpa_ram.sv
module nfpa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
